// ----- rtl/s16d_pkg.sv -----
// s16d_pkg: types and constants shared by the sum16 packet deframer.
// No dependencies.
package s16d_pkg;

  localparam int AddrWidth   = 32;
  localparam int MaxLenWidth = 16;
  localparam int LenWidth    = 16;
  localparam int TdataWidth  = 40;

  localparam logic [7:0] HdrByte1  = 8'hef;
  localparam logic [7:0] HdrByte2  = 8'h01;
  localparam logic [7:0] TypeMore  = 8'h02;
  localparam logic [7:0] TypeEnd   = 8'h08;
  localparam logic [15:0] LenMin   = 16'd2;

  localparam logic [0:0] CfgModuleAddress = 1'b0;
  localparam logic [0:0] CfgMaxLength     = 1'b1;

  typedef enum logic [3:0] {
    PH_HUNT    = 4'd0,
    PH_HDR2    = 4'd1,
    PH_ADDR    = 4'd2,
    PH_TYPE    = 4'd3,
    PH_LENHI   = 4'd4,
    PH_LENLO   = 4'd5,
    PH_PAYLOAD = 4'd6,
    PH_SUMHI   = 4'd7,
    PH_SUMLO   = 4'd8
  } phase_t;

  typedef enum logic [2:0] {
    ST_OTHER   = 3'd0,
    ST_MORE    = 3'd1,
    ST_END     = 3'd2,
    ST_BADHDR  = 3'd3,
    ST_BADADDR = 3'd4,
    ST_BADLEN  = 3'd5,
    ST_BADSUM  = 3'd6
  } status_t;

  typedef struct packed {
    logic                kind;
    logic [7:0]          data_byte;
    status_t             status;
    logic [7:0]          packet_type;
    logic [LenWidth-1:0] payload_length;
    logic                last;
  } result_t;

endpackage

// ----- rtl/s16d_parser.sv -----
// s16d_parser: framing state machine, address/length checks and running sum.
// Processes one accepted byte per cycle. Depends on s16d_pkg.
module s16d_parser
  import s16d_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_fire,
  input  logic [7:0]             rx_byte,
  input  logic [AddrWidth-1:0]   module_address,
  input  logic [MaxLenWidth-1:0] max_length_field,
  output logic                   res_valid,
  output result_t                res
);

  phase_t        phase, phase_next;
  logic [1:0]    address_byte_index, address_byte_index_next;
  logic [15:0]   length_value, length_value_next;
  logic [15:0]   bytes_remaining, bytes_remaining_next;
  logic [15:0]   running_sum, running_sum_next;
  logic [7:0]    type_byte, type_byte_next;
  logic          sum_high_ok, sum_high_ok_next;

  logic [7:0]    want_byte;
  logic [15:0]   len_full;
  logic [15:0]   sum_add;
  logic [15:0]   plen;

  always_comb begin
    case (address_byte_index)
      2'd0:    want_byte = module_address[31:24];
      2'd1:    want_byte = module_address[23:16];
      2'd2:    want_byte = module_address[15:8];
      default: want_byte = module_address[7:0];
    endcase
  end

  assign len_full = {length_value[15:8], rx_byte};
  assign sum_add  = running_sum + {8'd0, rx_byte};
  assign plen     = length_value - LenMin;

  // next state
  always_comb begin
    phase_next              = phase;
    address_byte_index_next = address_byte_index;
    length_value_next       = length_value;
    bytes_remaining_next    = bytes_remaining;
    running_sum_next        = running_sum;
    type_byte_next          = type_byte;
    sum_high_ok_next        = sum_high_ok;
    case (phase)
      PH_HUNT: begin
        if (rx_byte == HdrByte1) begin
          type_byte_next    = 8'd0;
          length_value_next = 16'd0;
          phase_next        = PH_HDR2;
        end
      end
      PH_HDR2: begin
        if (rx_byte != HdrByte2) begin
          phase_next = PH_HUNT;
        end else begin
          address_byte_index_next = 2'd0;
          phase_next              = PH_ADDR;
        end
      end
      PH_ADDR: begin
        if (rx_byte != want_byte) begin
          phase_next = PH_HUNT;
        end else begin
          address_byte_index_next = address_byte_index + 2'd1;
          if (address_byte_index == 2'd3) phase_next = PH_TYPE;
        end
      end
      PH_TYPE: begin
        type_byte_next   = rx_byte;
        running_sum_next = {8'd0, rx_byte};
        phase_next       = PH_LENHI;
      end
      PH_LENHI: begin
        length_value_next = {rx_byte, 8'd0};
        running_sum_next  = sum_add;
        phase_next        = PH_LENLO;
      end
      PH_LENLO: begin
        length_value_next    = len_full;
        running_sum_next     = sum_add;
        bytes_remaining_next = len_full - LenMin;
        if (len_full < LenMin || len_full > max_length_field) begin
          phase_next = PH_HUNT;
        end else if (len_full == LenMin) begin
          phase_next = PH_SUMHI;
        end else begin
          phase_next = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        running_sum_next     = sum_add;
        bytes_remaining_next = bytes_remaining - 16'd1;
        if (bytes_remaining == 16'd1) phase_next = PH_SUMHI;
      end
      PH_SUMHI: begin
        sum_high_ok_next = (rx_byte == running_sum[15:8]);
        phase_next       = PH_SUMLO;
      end
      PH_SUMLO: begin
        sum_high_ok_next = 1'b0;
        phase_next       = PH_HUNT;
      end
      default: phase_next = PH_HUNT;
    endcase
  end

  // result
  always_comb begin
    res_valid          = 1'b0;
    res.kind           = 1'b1;
    res.data_byte      = 8'd0;
    res.status         = ST_OTHER;
    res.packet_type    = type_byte;
    res.payload_length = 16'd0;
    res.last           = 1'b1;
    case (phase)
      PH_HDR2: begin
        if (rx_byte != HdrByte2) begin
          res_valid  = 1'b1;
          res.status = ST_BADHDR;
        end
      end
      PH_ADDR: begin
        if (rx_byte != want_byte) begin
          res_valid  = 1'b1;
          res.status = ST_BADADDR;
        end
      end
      PH_LENLO: begin
        if (len_full < LenMin || len_full > max_length_field) begin
          res_valid  = 1'b1;
          res.status = ST_BADLEN;
        end
      end
      PH_PAYLOAD: begin
        res_valid          = 1'b1;
        res.kind           = 1'b0;
        res.data_byte      = rx_byte;
        res.payload_length = plen;
        res.last           = 1'b0;
      end
      PH_SUMLO: begin
        res_valid          = 1'b1;
        res.payload_length = plen;
        if (!sum_high_ok || rx_byte != running_sum[7:0]) begin
          res.status = ST_BADSUM;
        end else if (type_byte == TypeMore) begin
          res.status = ST_MORE;
        end else if (type_byte == TypeEnd) begin
          res.status = ST_END;
        end else begin
          res.status = ST_OTHER;
        end
      end
      default: res_valid = 1'b0;
    endcase
    if (!in_fire) res_valid = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase              <= PH_HUNT;
      address_byte_index <= 2'd0;
      length_value       <= 16'd0;
      bytes_remaining    <= 16'd0;
      running_sum        <= 16'd0;
      type_byte          <= 8'd0;
      sum_high_ok        <= 1'b0;
    end else if (in_fire) begin
      phase              <= phase_next;
      address_byte_index <= address_byte_index_next;
      length_value       <= length_value_next;
      bytes_remaining    <= bytes_remaining_next;
      running_sum        <= running_sum_next;
      type_byte          <= type_byte_next;
      sum_high_ok        <= sum_high_ok_next;
    end
  end

endmodule

// ----- rtl/s16d_out_reg.sv -----
// s16d_out_reg: result register driving the output stream.
// Depends on s16d_pkg.
module s16d_out_reg
  import s16d_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load,
  input  result_t               res,
  output logic                  can_load,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [TdataWidth-1:0] m_tdata,
  output logic                  m_tuser,
  output logic                  m_tlast
);

  result_t held;

  assign can_load = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (can_load) begin
      m_tvalid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (can_load && load) held <= res;
  end

  assign m_tdata = {5'd0, held.payload_length, held.packet_type, held.status, held.data_byte};
  assign m_tuser = held.kind;
  assign m_tlast = held.last;

endmodule

// ----- rtl/sum16_packet_deframer.sv -----
// sum16_packet_deframer: byte-stream packet deframer, top level.
// Instantiates s16d_parser and s16d_out_reg; depends on s16d_pkg.
//
// Input stream carries one received byte per beat. Packets are EF 01, a
// 4-byte module address (MSB first), a type byte, a 16-bit big-endian
// length, length-2 payload bytes and a 16-bit sum (high byte first).
// Each payload byte comes out as a beat with m_tuser low; each packet or
// failed attempt closes with one status beat, m_tuser and m_tlast high.
// Bytes that produce no beat (header, address, type, length, sum high)
// are simply consumed.
// Each output beat is registered and appears in the cycle after its input
// beat. One byte is taken per cycle while s_tready is high, set by the single
// parser stage and the result register. s_tready drops only while a result
// sits in the output register and the receiver stalls; the input then waits
// until that beat is taken. Reset returns the parser to hunting for the header,
// empties the output register and restores address FFFFFFFF and max length 1015.
// Config writes (cfg_we) are registered; index 0 address, 1 max length.
module sum16_packet_deframer
  import s16d_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [AddrWidth-1:0]  cfg_data,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [7:0]            s_tdata,   // [7:0] rx_byte
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // [7:0] data_byte, [10:8] status, [18:11] packet_type,
  // [34:19] payload_length, [39:35] zero
  output logic [TdataWidth-1:0] m_tdata,
  output logic                  m_tuser,   // [0] kind
  output logic                  m_tlast
);

  logic [AddrWidth-1:0]   module_address;
  logic [MaxLenWidth-1:0] max_length_field;
  logic                   in_fire;
  logic                   res_valid;
  result_t                res;

  always_ff @(posedge clk) begin
    if (rst) begin
      module_address   <= '1;
      max_length_field <= 16'd1015;
    end else if (cfg_we) begin
      case (cfg_index)
        CfgModuleAddress: module_address   <= cfg_data;
        CfgMaxLength:     max_length_field <= cfg_data[MaxLenWidth-1:0];
        default:          module_address   <= module_address;
      endcase
    end
  end

  assign in_fire = s_tvalid && s_tready;

  s16d_parser u_parser (
    .clk              (clk),
    .rst              (rst),
    .in_fire          (in_fire),
    .rx_byte          (s_tdata),
    .module_address   (module_address),
    .max_length_field (max_length_field),
    .res_valid        (res_valid),
    .res              (res)
  );

  s16d_out_reg u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (res_valid),
    .res      (res),
    .can_load (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

`ifndef NO_ASSERTIONS
  a_kind_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser == m_tlast))
    else $error("status beat without tlast or payload beat with tlast");

  a_status_no_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> (m_tdata[7:0] == 8'd0))
    else $error("status beat carries a data byte");

  a_payload_no_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> (m_tdata[10:8] == ST_OTHER))
    else $error("payload beat carries a status code");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output register");
`endif

endmodule
